>>> rtl/core/cross_channel_dedup_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cross-channel dedup filter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CROSS_CHANNEL_DEDUP_FILTER_CORE_DEFINES_SVH
`define CROSS_CHANNEL_DEDUP_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CCDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccdf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccdf: next-cycle check failed");

`else

`define CCDF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/ccdf_pkg.sv
// ----------------------------------------------------------------------------
// ccdf_pkg
// Widths, register indexes, reset values and the ring entry type of the
// cross-channel dedup filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ccdf_pkg;

    localparam int HASH_W    = 32;
    localparam int FREQ_W    = 33;
    localparam int TSTAMP_W  = 63;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int RING_DEPTH = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ    = 1'b1;

    localparam logic [CFG_W-1:0] TIME_WINDOW_RST = 32'd1000000;
    localparam logic [CFG_W-1:0] MIN_FREQ_RST    = 32'd1000;

    typedef struct packed {
        logic [HASH_W-1:0]   hash;
        logic [FREQ_W-1:0]   freq;
        logic [TSTAMP_W-1:0] tstamp;
    } t_entry;

endpackage

`default_nettype wire

>>> rtl/core/ccdf_ram.sv
// ----------------------------------------------------------------------------
// ccdf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/cross_channel_dedup_filter_core.sv
// ----------------------------------------------------------------------------
// cross_channel_dedup_filter_core
// Drops a decode when the same fingerprint was recently recorded on a
// channel whose frequency is clearly different.
// ----------------------------------------------------------------------------
// Usage:
// A decode (hash, channel frequency, timestamp) is taken when start is high
// and busy is low. The core then walks the filled part of a ring memory, one
// entry read per cycle, through a read / difference / compare pipeline.
// After the walk it pulses o_valid for one cycle with o_suppress. A decode
// that is not suppressed is written at the ring head at the edge that raises
// o_valid. Busy stays high from the accepting edge until every recorded entry
// (at most RING_DEPTH) has been read and the pipeline has drained; the single
// memory read port serves the walk. A new decode can be taken in the strobe
// cycle, but not while a walk is in progress.
// The receiver cannot stall: the result is shown for exactly one cycle.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do so only while the core is idle, as the core does not enforce
// it. Reset empties the ring (fill count and head go to zero) and restores
// the window and frequency-difference registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cross_channel_dedup_filter_core_defines.svh"

module cross_channel_dedup_filter_core #(
    parameter int RING_DEPTH = ccdf_pkg::RING_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [ccdf_pkg::HASH_W-1:0]      i_record_hash,
    input  wire logic [ccdf_pkg::FREQ_W-1:0]      i_channel_freq_hz,
    input  wire logic [ccdf_pkg::TSTAMP_W-1:0]    i_now_us,
    output logic                                  o_valid,
    output logic                                  o_suppress,
    input  wire logic                             i_cfg_we,
    input  wire logic [ccdf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ccdf_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int HASH_W  = ccdf_pkg::HASH_W;
    localparam int FREQ_W  = ccdf_pkg::FREQ_W;
    localparam int TS_W    = ccdf_pkg::TSTAMP_W;
    localparam int CFG_W   = ccdf_pkg::CFG_W;
    localparam int ENTRY_W = $bits(ccdf_pkg::t_entry);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_scan_cnt, n_scan_cnt;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]   r_wptr, n_wptr;
    logic               r_v1, n_v1;
    logic               r_v2, n_v2;
    logic               r_hit, n_hit;
    logic               r_valid, n_valid;
    logic               r_suppress, n_suppress;
    logic [CFG_W-1:0]   r_window, n_window;
    logic [CFG_W-1:0]   r_min_diff, n_min_diff;

    // Latched decode and pipeline payload.
    logic [HASH_W-1:0]  r_hash;
    logic [FREQ_W-1:0]  r_freq;
    logic [TS_W-1:0]    r_now;
    logic               r_heq;
    logic [TS_W:0]      r_tdiff;
    logic [FREQ_W:0]    r_fd_ab;
    logic [FREQ_W:0]    r_fd_ba;

    ccdf_pkg::t_entry   w_rd_entry;
    ccdf_pkg::t_entry   w_wr_entry;
    logic [ENTRY_W-1:0] w_rdata;
    logic               w_accept;
    logic               w_issue;
    logic               w_finish;
    logic               w_we;
    logic               w_recent;
    logic               w_far;
    logic               w_match;

    ccdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH),
        .AW    (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (w_wr_entry),
        .i_raddr (r_scan_cnt[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd_entry = ccdf_pkg::t_entry'(w_rdata);
    assign w_wr_entry = '{hash: r_hash, freq: r_freq, tstamp: r_now};

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_issue  = (r_state == ST_SCAN) && (r_scan_cnt != r_fill);
    assign w_finish = (r_state == ST_SCAN) && !w_issue && !r_v1 && !r_v2;
    assign w_we     = w_finish && !r_hit;

    // A negative age counts as recent.
    assign w_recent = r_tdiff[TS_W] || (r_tdiff[TS_W-1:0] <= TS_W'(r_window));
    assign w_far    = (!r_fd_ab[FREQ_W] && (r_fd_ab[FREQ_W-1:0] > FREQ_W'(r_min_diff)))
                   || (!r_fd_ba[FREQ_W] && (r_fd_ba[FREQ_W-1:0] > FREQ_W'(r_min_diff)));
    assign w_match  = r_v2 && r_heq && w_recent && w_far;

    always_comb begin
        n_state    = r_state;
        n_scan_cnt = r_scan_cnt;
        n_fill     = r_fill;
        n_wptr     = r_wptr;
        n_v1       = w_issue;
        n_v2       = r_v1;
        n_hit      = r_hit;
        n_valid    = 1'b0;
        n_suppress = r_suppress;
        n_window   = r_window;
        n_min_diff = r_min_diff;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ccdf_pkg::CFG_TIME_WINDOW: n_window   = i_cfg_data;
                ccdf_pkg::CFG_MIN_FREQ:    n_min_diff = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state    = ST_SCAN;
                    n_scan_cnt = '0;
                    n_hit      = 1'b0;
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_scan_cnt = r_scan_cnt + CNT_W'(1);
                end
                if (w_match) begin
                    n_hit = 1'b1;
                end
                if (w_finish) begin
                    n_state    = ST_IDLE;
                    n_valid    = 1'b1;
                    n_suppress = r_hit;
                    if (!r_hit) begin
                        n_wptr = (r_wptr == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                  : r_wptr + IDX_W'(1);
                        if (r_fill != CNT_W'(RING_DEPTH)) begin
                            n_fill = r_fill + CNT_W'(1);
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_scan_cnt <= '0;
            r_fill     <= '0;
            r_wptr     <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_hit      <= 1'b0;
            r_valid    <= 1'b0;
            r_suppress <= 1'b0;
            r_window   <= ccdf_pkg::TIME_WINDOW_RST;
            r_min_diff <= ccdf_pkg::MIN_FREQ_RST;
        end else begin
            r_state    <= n_state;
            r_scan_cnt <= n_scan_cnt;
            r_fill     <= n_fill;
            r_wptr     <= n_wptr;
            r_v1       <= n_v1;
            r_v2       <= n_v2;
            r_hit      <= n_hit;
            r_valid    <= n_valid;
            r_suppress <= n_suppress;
            r_window   <= n_window;
            r_min_diff <= n_min_diff;
        end
    end

    // Datapath: the decode is held for the whole walk; the difference stage
    // works on whatever the memory returned last cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hash <= i_record_hash;
            r_freq <= i_channel_freq_hz;
            r_now  <= i_now_us;
        end
        r_heq   <= (w_rd_entry.hash == r_hash);
        r_tdiff <= {1'b0, r_now} - {1'b0, w_rd_entry.tstamp};
        r_fd_ab <= {1'b0, r_freq} - {1'b0, w_rd_entry.freq};
        r_fd_ba <= {1'b0, w_rd_entry.freq} - {1'b0, r_freq};
    end

    assign o_valid    = r_valid;
    assign o_suppress = r_suppress;

    `CCDF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, busy)
    `CCDF_ASSERT_IMPL(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `CCDF_ASSERT_NEXT(a_record_only_on_pass, i_clk, i_rst_n, w_we, o_valid && !o_suppress)
    `CCDF_ASSERT_IMPL(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(RING_DEPTH))
    `CCDF_ASSERT_IMPL(a_pipe_in_scan, i_clk, i_rst_n, r_v1 || r_v2, r_state == ST_SCAN)

endmodule

`default_nettype wire
